### rtl/core/otx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// OOK transmitter and sampler package
// Item kinds and the item structures shared by the top level and the engine.
// ----------------------------------------------------------------------------
package otx_pkg;

    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_FILL        = 3'd1,
        KIND_CLEAR       = 3'd2,
        KIND_SEND        = 3'd3,
        KIND_CAPTURE_ON  = 3'd4,
        KIND_CAPTURE_OFF = 3'd5
    } t_kind;

    localparam int unsigned BYTE_BITS = 8;

    typedef struct packed {
        logic [2:0] kind;
        logic       rx_sample;
        logic [7:0] data_byte;
        logic [7:0] repeat_count;
    } t_in_item;

    typedef struct packed {
        logic       tx_level;
        logic       heartbeat;
        logic       byte_ready;
        logic [7:0] captured_byte;
        logic       block_last;
        logic       busy_res;
    } t_out_item;

endpackage
`default_nettype wire

### rtl/core/otx_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one command or tick item.
// ----------------------------------------------------------------------------
interface otx_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       rx_sample;
    logic [7:0] data_byte;
    logic [7:0] repeat_count;

    modport source (output valid, output kind, output rx_sample, output data_byte,
                    output repeat_count, input ready);
    modport sink   (input valid, input kind, input rx_sample, input data_byte,
                    input repeat_count, output ready);
endinterface
`default_nettype wire

### rtl/core/otx_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one status item per accepted input item.
// ----------------------------------------------------------------------------
interface otx_out_if;
    logic       valid;
    logic       ready;
    logic       tx_level;
    logic       heartbeat;
    logic       byte_ready;
    logic [7:0] captured_byte;
    logic       block_last;
    logic       busy_res;

    modport source (output valid, output tx_level, output heartbeat, output byte_ready,
                    output captured_byte, output block_last, output busy_res,
                    input ready);
    modport sink   (input valid, input tx_level, input heartbeat, input byte_ready,
                    input captured_byte, input block_last, input busy_res,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/otx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module otx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/otx_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// OOK engine
// Holds the transmit store and all line state, and turns one item into its
// status item combinationally.
// ----------------------------------------------------------------------------
module otx_engine #(
    parameter int unsigned STORE_BYTES = 128,
    parameter int unsigned BLOCK_BYTES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire otx_pkg::t_in_item i_item,
    output otx_pkg::t_out_item     o_res
);

    localparam int unsigned LEN_W = $clog2(STORE_BYTES + 1);
    localparam int unsigned CNT_W = $clog2(STORE_BYTES * 8 + 1);
    localparam int unsigned IDX_W = CNT_W - 3;
    localparam int unsigned AW    = $clog2(STORE_BYTES);
    localparam int unsigned CAP_W = $clog2(BLOCK_BYTES * 8 + 1);
    localparam logic [LEN_W-1:0] STORE_LEN  = LEN_W'(STORE_BYTES);
    localparam logic [CAP_W-1:0] BLOCK_BITS = CAP_W'(BLOCK_BYTES * 8);

    logic [LEN_W-1:0] r_len,     n_len;
    logic [LEN_W-1:0] r_hw,      n_hw;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [CNT_W-1:0] r_reload,  n_reload;
    logic [7:0]       r_reps,    n_reps;
    logic             r_cap_en,  n_cap_en;
    logic [7:0]       r_shift,   n_shift;
    logic [CAP_W-1:0] r_cap_cnt, n_cap_cnt;
    logic             r_line,    n_line;
    logic             r_beat,    n_beat;
    logic             r_rd_ok,   n_rd_ok;
    logic             r_byp,     n_byp;
    logic [7:0]       r_byp_data;

    logic             we;
    logic [7:0]       ram_q;
    logic [7:0]       tx_byte;
    logic             tx_bit;
    logic [IDX_W-1:0] rd_idx;
    logic [CAP_W-1:0] cap_inc;
    logic             ready;
    logic             last;
    otx_pkg::t_kind   kind;

    assign kind = otx_pkg::t_kind'(i_item.kind);

    // The byte for the next tick is read from the RAM at the counter's next value,
    // so its registered data is ready when the counter takes it; a fill to the same entry meanwhile is forwarded.
    assign tx_byte = !r_rd_ok ? 8'd0 : (r_byp ? r_byp_data : ram_q);
    assign tx_bit  = tx_byte[3'(3'd0 - r_cnt[2:0])];
    assign cap_inc = r_cap_cnt + CAP_W'(1);

    always_comb begin
        n_len     = r_len;
        n_hw      = r_hw;
        n_cnt     = r_cnt;
        n_reload  = r_reload;
        n_reps    = r_reps;
        n_cap_en  = r_cap_en;
        n_shift   = r_shift;
        n_cap_cnt = r_cap_cnt;
        n_line    = r_line;
        n_beat    = r_beat;
        we        = 1'b0;
        ready     = 1'b0;
        last      = 1'b0;
        if (i_fire) begin
            unique case (kind)
                otx_pkg::KIND_TICK: begin
                    n_beat = ~r_beat;
                    if (r_cnt != '0) begin
                        n_line = ~tx_bit;
                        n_cnt  = r_cnt - CNT_W'(1);
                    end else if (r_reps != '0) begin
                        n_cnt  = r_reload;
                        n_reps = r_reps - 8'd1;
                    end else begin
                        n_line = 1'b0;
                        if (r_cap_en) begin
                            n_shift   = {r_shift[6:0], i_item.rx_sample};
                            n_cap_cnt = cap_inc;
                            ready     = (cap_inc[2:0] == 3'd0);
                            if (cap_inc >= BLOCK_BITS) begin
                                n_cap_cnt = '0;
                                last      = ready;
                            end
                        end
                    end
                end
                otx_pkg::KIND_FILL: begin
                    if (r_len < STORE_LEN) begin
                        we    = 1'b1;
                        n_len = r_len + LEN_W'(1);
                        if (r_len == r_hw) begin
                            n_hw = r_hw + LEN_W'(1);
                        end
                    end
                end
                otx_pkg::KIND_CLEAR: begin
                    n_len = '0;
                end
                otx_pkg::KIND_SEND: begin
                    n_cap_en = 1'b0;
                    n_cnt    = '0;
                    n_reload = CNT_W'({r_len, 3'b000});
                    n_reps   = i_item.repeat_count;
                end
                otx_pkg::KIND_CAPTURE_ON: begin
                    n_cap_en = 1'b1;
                end
                otx_pkg::KIND_CAPTURE_OFF: begin
                    n_cap_en = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Entries at or beyond the fill high-water mark were never written since
    // reset and read as zero, as does any index past the store.
    assign rd_idx  = n_cnt[CNT_W-1:3];
    assign n_rd_ok = (rd_idx < IDX_W'(n_hw));
    assign n_byp   = we && (rd_idx == IDX_W'(r_len));

    always_comb begin
        o_res.tx_level      = n_line;
        o_res.heartbeat     = n_beat;
        o_res.byte_ready    = ready;
        o_res.captured_byte = ready ? n_shift : 8'd0;
        o_res.block_last    = last;
        o_res.busy_res      = (n_cnt != '0) || (n_reps != '0);
    end

    otx_ram #(
        .WIDTH (otx_pkg::BYTE_BITS),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_item.data_byte),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_hw      <= '0;
            r_cnt     <= '0;
            r_reload  <= '0;
            r_reps    <= '0;
            r_cap_en  <= 1'b0;
            r_shift   <= '0;
            r_cap_cnt <= '0;
            r_line    <= 1'b0;
            r_beat    <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_hw      <= n_hw;
            r_cnt     <= n_cnt;
            r_reload  <= n_reload;
            r_reps    <= n_reps;
            r_cap_en  <= n_cap_en;
            r_shift   <= n_shift;
            r_cap_cnt <= n_cap_cnt;
            r_line    <= n_line;
            r_beat    <= n_beat;
            r_rd_ok   <= n_rd_ok;
            r_byp     <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_item.data_byte;
    end

    a_len_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= r_hw && r_hw <= STORE_LEN)
        else $error("store length above fill high-water mark");

    a_cap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_cnt < BLOCK_BITS)
        else $error("capture bit count left inside a full block");

    a_ready_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.byte_ready |-> (i_fire && kind == otx_pkg::KIND_TICK && r_cap_en))
        else $error("capture byte reported outside a capture tick");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && kind == otx_pkg::KIND_FILL && r_len == STORE_LEN) |=> $stable(r_len))
        else $error("fill into a full store changed its length");

endmodule
`default_nettype wire

### rtl/core/ook_bit_transmitter_and_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// OOK bit transmitter and sampler
// Tick-driven raw radio line engine with a transmit store and byte capture.
// ----------------------------------------------------------------------------
// Each item on i_in (a tick or a command) produces exactly one status item on
// o_out. The block takes one item per clock cycle while o_out is not stalled;
// an item goes through an input register and a result register, so its status
// is valid on o_out from the clock edge after the one that accepts it when o_out
// is not stalled, and a held result does not stop the next item from entering
// an empty input register. The transmit store is a RAM whose read for the next
// tick is issued ahead of it from the counter's next value. After reset the
// store reads as zero past the high-water mark of bytes filled so far, so no
// clearing pass is needed and the block accepts items right out of reset.
module ook_bit_transmitter_and_sampler #(
    parameter int unsigned STORE_BYTES = 128,
    parameter int unsigned BLOCK_BYTES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    otx_in_if.sink     i_in,
    otx_out_if.source  o_out
);

    logic               r_in_valid;
    otx_pkg::t_in_item  r_in;
    logic               r_out_valid;
    otx_pkg::t_out_item r_out;
    otx_pkg::t_out_item res;
    logic               fire;
    logic               in_take;

    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.kind         <= i_in.kind;
            r_in.rx_sample    <= i_in.rx_sample;
            r_in.data_byte    <= i_in.data_byte;
            r_in.repeat_count <= i_in.repeat_count;
        end
    end

    otx_engine #(
        .STORE_BYTES (STORE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tx_level      = r_out.tx_level;
    assign o_out.heartbeat     = r_out.heartbeat;
    assign o_out.byte_ready    = r_out.byte_ready;
    assign o_out.captured_byte = r_out.captured_byte;
    assign o_out.block_last    = r_out.block_last;
    assign o_out.busy_res      = r_out.busy_res;

endmodule
`default_nettype wire
